@@ rtl/core/bfpa_pkg.sv @@
// shared types and constants for the best-fit page allocator
// no dependencies
package bfpa_pkg;

	localparam int unsigned NumPagesDef  = 1024;
	localparam int unsigned PageBytesDef = 4096;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOSPACE  = 3'd1;
	localparam logic [2:0] ST_DISABLED = 3'd2;
	localparam logic [2:0] ST_ZERO     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_BASE   = 1'b1;

	typedef enum logic [10:0] {
		S_CLEAR  = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_SCAN   = 11'b00000000100,
		S_SEND   = 11'b00000001000,
		S_SCHK   = 11'b00000010000,
		S_MARK   = 11'b00000100000,
		S_APPEND = 11'b00001000000,
		S_FSCAN  = 11'b00010000000,
		S_FWAIT  = 11'b00100000000,
		S_FCLR   = 11'b01000000000,
		S_FMOVE  = 11'b10000000000
	} state_t;

	typedef enum logic [1:0] {
		BM_CLEAR = 2'd0,
		BM_MARK  = 2'd1,
		BM_FREE  = 2'd2
	} bm_sel_t;

	typedef struct packed {
		logic       load;
		logic       ctr_clr;
		logic       ctr_inc;
		logic       bm_wr;
		bm_sel_t    bm_sel;
		logic       bm_rd;
		logic       scan_rst;
		logic       ent_rd;
		logic       ent_rd_last;
		logic       ent_append;
		logic       ent_move;
		logic       hit_cap;
		logic       out_load;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic ctr_last_page;
		logic ctr_last_need;
		logic ctr_last_hit;
		logic ctr_last_ent;
		logic ent_hit;
		logic ent_empty;
		logic found;
		logic chk_zero;
		logic chk_big;
		logic enable;
		logic out_busy;
	} stat_t;

endpackage

@@ rtl/core/best_fit_page_allocator.sv @@
// best-fit page allocator top level: controller and datapath, stream ports
// allocate scans the bitmap one bit per cycle for the best-fit run, marks it, adds an entry;
// free finds the entry in the table, clears its pages and moves the last entry into its slot
// one request at a time; after reset the whole bitmap is cleared first, no requests taken
// depends on bfpa_pkg, bfpa_ctrl, bfpa_dp
module best_fit_page_allocator
	import bfpa_pkg::*;
#(
	parameter int unsigned NUM_PAGES  = NumPagesDef,
	parameter int unsigned PAGE_BYTES = PageBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // request_bytes, region_address
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // result_address, status, region_bytes, zero pad
);

	cmd_t        cmd;
	stat_t       stat;
	logic [31:0] res_addr;
	logic [2:0]  res_status;
	logic [22:0] res_bytes;

	bfpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bfpa_dp #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.in_request_bytes   (s_tdata[31:0]),
		.in_region_address  (s_tdata[63:32]),
		.in_op              (s_tuser),
		.cmd                (cmd),
		.stat               (stat),
		.out_valid          (m_tvalid),
		.out_ready          (m_tready),
		.out_result_address (res_addr),
		.out_status         (res_status),
		.out_region_bytes   (res_bytes)
	);

	assign m_tdata = {6'd0, res_bytes, res_status, res_addr};

endmodule

@@ rtl/core/bfpa_ctrl.sv @@
// controller state machine for the best-fit page allocator
// depends on bfpa_pkg
module bfpa_ctrl
	import bfpa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_op,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t     state_q, state_d;
	logic [2:0] st_q, st_d;
	logic       send_q, send_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			st_q    <= ST_OK;
			send_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			send_q  <= send_d;
		end
	end

	assign in_ready = (state_q == S_IDLE) && !send_q;

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		send_d  = send_q;
		cmd     = '0;
		cmd.bm_sel = BM_CLEAR;
		cmd.status = st_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.bm_wr   = 1'b1;
				cmd.ctr_inc = 1'b1;
				if (stat.ctr_last_page) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (send_q) begin
					if (!stat.out_busy) begin
						cmd.out_load = 1'b1;
						send_d = 1'b0;
					end
				end else if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.ctr_clr = 1'b1;
					cmd.scan_rst = 1'b1;
					if (in_op == OP_ALLOC) begin
						priority if (!stat.enable) begin
							st_d = ST_DISABLED; send_d = 1'b1;
						end else if (stat.chk_zero) begin
							st_d = ST_ZERO; send_d = 1'b1;
						end else if (stat.chk_big) begin
							st_d = ST_NOSPACE; send_d = 1'b1;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						if (stat.ent_empty) begin
							st_d = ST_NOTFOUND; send_d = 1'b1;
						end else begin
							state_d = S_FSCAN;
						end
					end
				end
			end
			S_SCAN: begin
				cmd.bm_rd   = 1'b1;
				cmd.ctr_inc = 1'b1;
				if (stat.ctr_last_page) begin
					state_d = S_SEND;
				end
			end
			S_SEND: state_d = S_SCHK;
			S_SCHK: begin
				cmd.ctr_clr = 1'b1;
				if (stat.found) begin
					state_d = S_MARK;
				end else begin
					st_d = ST_NOSPACE; send_d = 1'b1; state_d = S_IDLE;
				end
			end
			S_MARK: begin
				cmd.bm_wr   = 1'b1;
				cmd.bm_sel  = BM_MARK;
				cmd.ctr_inc = 1'b1;
				if (stat.ctr_last_need) begin
					state_d = S_APPEND;
				end
			end
			S_APPEND: begin
				cmd.ent_append = 1'b1;
				st_d = ST_OK; send_d = 1'b1; state_d = S_IDLE;
			end
			S_FSCAN: begin
				if (stat.ent_hit) begin
					cmd.hit_cap = 1'b1;
					cmd.ctr_clr = 1'b1;
					state_d = S_FCLR;
				end else begin
					cmd.ent_rd  = 1'b1;
					cmd.ctr_inc = 1'b1;
					if (stat.ctr_last_ent) begin
						state_d = S_FWAIT;
					end
				end
			end
			S_FWAIT: begin
				if (stat.ent_hit) begin
					cmd.hit_cap = 1'b1;
					cmd.ctr_clr = 1'b1;
					state_d = S_FCLR;
				end else begin
					st_d = ST_NOTFOUND; send_d = 1'b1; state_d = S_IDLE;
				end
			end
			S_FCLR: begin
				cmd.bm_wr   = 1'b1;
				cmd.bm_sel  = BM_FREE;
				cmd.ctr_inc = 1'b1;
				if (stat.ctr_last_hit) begin
					cmd.ent_rd_last = 1'b1;
					state_d = S_FMOVE;
				end
			end
			S_FMOVE: begin
				cmd.ent_move = 1'b1;
				st_d = ST_OK; send_d = 1'b1; state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/core/bfpa_dp.sv @@
// datapath of the best-fit page allocator: bitmap, allocation table, scan and result
// depends on bfpa_pkg
module bfpa_dp
	import bfpa_pkg::*;
#(
	parameter int unsigned NUM_PAGES  = NumPagesDef,
	parameter int unsigned PAGE_BYTES = PageBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic [31:0] in_request_bytes,
	input  logic [31:0] in_region_address,
	input  logic        in_op,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_result_address,
	output logic [2:0]  out_status,
	output logic [22:0] out_region_bytes
);

	localparam int unsigned PW    = $clog2(NUM_PAGES);
	localparam int unsigned SHIFT = $clog2(PAGE_BYTES);
	localparam int unsigned NW    = 33 - SHIFT;

	logic              enable_q;
	logic [31:0]       base_q;
	logic [31:0]       addr_q;
	logic              op_q;
	logic [PW:0]       ctr_q, need_q, ent_cnt_q, hit_cnt_q, pages_q;
	logic [PW-1:0]     best_start_q, hit_start_q, hit_idx_q, run_start_q;
	logic [PW:0]       best_len_q, run_len_q;
	logic              found_q;
	logic              bm_mem [NUM_PAGES];
	logic [2*PW:0]     ent_mem [NUM_PAGES];
	logic              bm_s1, bm_vld_s1, ent_vld_s1;
	logic [PW-1:0]     idx_s1;
	logic [2*PW:0]     ent_s1;
	logic              ov_q;

	logic [32:0]       need_sum;
	logic [NW-1:0]     need_full;
	logic [PW-1:0]     bm_waddr, ent_raddr;
	logic              ev;
	logic [PW:0]       elen;
	logic [PW-1:0]     estart;
	logic [31:0]       ent_addr;

	assign need_sum  = {1'b0, in_request_bytes} + 33'(PAGE_BYTES - 1);
	assign need_full = NW'(need_sum >> SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			base_q   <= 32'h8000_0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_wdata[0];
				CFG_BASE:   base_q   <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q      <= '0;
			ent_cnt_q  <= '0;
			bm_vld_s1  <= 1'b0;
			ent_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			if (cmd.ctr_clr) begin
				ctr_q <= '0;
			end else if (cmd.ctr_inc) begin
				ctr_q <= ctr_q + 1'b1;
			end
			bm_vld_s1  <= cmd.bm_rd;
			ent_vld_s1 <= cmd.ent_rd;
			if (cmd.ent_append) begin
				ent_cnt_q <= ent_cnt_q + 1'b1;
			end else if (cmd.ent_move) begin
				ent_cnt_q <= ent_cnt_q - 1'b1;
			end
			if (cmd.scan_rst) begin
				found_q <= 1'b0;
			end else if (bm_vld_s1 && ev && elen >= need_q && (!found_q || elen < best_len_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// request capture and scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q  <= in_region_address;
			op_q    <= in_op;
			need_q  <= need_full[PW:0];
			pages_q <= need_full[PW:0];
		end
		if (cmd.scan_rst) begin
			run_len_q <= '0;
		end else if (bm_vld_s1) begin
			run_len_q   <= bm_s1 ? '0 : run_len_q + 1'b1;
			run_start_q <= estart;
			if (ev && elen >= need_q && (!found_q || elen < best_len_q)) begin
				best_start_q <= estart;
				best_len_q   <= elen;
			end
		end
		if (cmd.hit_cap) begin
			hit_idx_q   <= idx_s1;
			hit_start_q <= ent_s1[2*PW:PW+1];
			hit_cnt_q   <= ent_s1[PW:0];
			pages_q     <= ent_s1[PW:0];
		end
	end

	assign ev     = (bm_s1 && run_len_q != '0) || (!bm_s1 && idx_s1 == PW'(NUM_PAGES - 1));
	assign elen   = bm_s1 ? run_len_q : run_len_q + 1'b1;
	assign estart = (!bm_s1 && run_len_q == '0) ? idx_s1 : run_start_q;

	// page bitmap
	always_comb begin
		unique case (cmd.bm_sel)
			BM_MARK: bm_waddr = best_start_q + ctr_q[PW-1:0];
			BM_FREE: bm_waddr = hit_start_q + ctr_q[PW-1:0];
			default: bm_waddr = ctr_q[PW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.bm_wr) begin
			bm_mem[bm_waddr] <= (cmd.bm_sel == BM_MARK);
		end
		bm_s1  <= bm_mem[ctr_q[PW-1:0]];
		idx_s1 <= ctr_q[PW-1:0];
	end

	// allocation table: start page, page count
	assign ent_raddr = cmd.ent_rd_last ? PW'(ent_cnt_q - 1'b1) : ctr_q[PW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.ent_append) begin
			ent_mem[ent_cnt_q[PW-1:0]] <= {best_start_q, need_q};
		end else if (cmd.ent_move) begin
			ent_mem[hit_idx_q] <= ent_s1;
		end
		ent_s1 <= ent_mem[ent_raddr];
	end

	assign ent_addr = base_q + (32'(ent_s1[2*PW:PW+1]) << SHIFT);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= cmd.status;
			if (cmd.status == ST_OK) begin
				out_result_address <= (op_q == OP_ALLOC)
					? base_q + (32'(best_start_q) << SHIFT) : 32'd0;
				out_region_bytes <= 23'((64'(pages_q)) << SHIFT);
			end else begin
				out_result_address <= 32'd0;
				out_region_bytes   <= 23'd0;
			end
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		stat.ctr_last_page = ctr_q == (PW+1)'(NUM_PAGES - 1);
		stat.ctr_last_need = ctr_q == need_q - 1'b1;
		stat.ctr_last_hit  = ctr_q == hit_cnt_q - 1'b1;
		stat.ctr_last_ent  = ctr_q == ent_cnt_q - 1'b1;
		stat.ent_hit       = ent_vld_s1 && ent_addr == addr_q;
		stat.ent_empty     = ent_cnt_q == '0;
		stat.found         = found_q;
		stat.chk_zero      = in_request_bytes == 32'd0;
		stat.chk_big       = need_full > NW'(NUM_PAGES);
		stat.enable        = enable_q;
		stat.out_busy      = ov_q && !out_ready;
	end

endmodule
